[design/frtc_pkg.sv]
// Shared types, codes and defaults for the free region table.
`default_nettype none

package frtc_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ADDR_BITS_DEF     = 32;

  // Region sizes are always full width
  localparam int SIZE_W = 32;

  // Request kinds
  localparam logic REQ_RELEASE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_INSERT     = 3'd0;
  localparam logic [2:0] ST_MERGE_NEXT = 3'd1;
  localparam logic [2:0] ST_MERGE_PREV = 3'd2;
  localparam logic [2:0] ST_MERGE_BOTH = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd5;
  localparam logic [2:0] ST_READ_OK    = 3'd6;

  // Input item
  typedef struct packed {
    logic        req_type;
    logic [31:0] region_start;
    logic [31:0] region_size;
    logic [5:0]  read_index;
  } req_t;

  // Result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_size;
    logic [31:0] entry_start;
    logic [6:0]  entries_used;
  } rsp_t;

  // Update applied by every cell in the same cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_MERGE_NEXT,
    OP_MERGE_PREV,
    OP_MERGE_BOTH
  } cell_op_t;

  // Control broadcast to the cell row
  typedef struct packed {
    logic     eval;
    logic     apply;
    cell_op_t op;
  } cell_ctl_t;

  // Per-cell position and match flags, registered in the compare cycle
  typedef struct packed {
    logic pos;   // first cell that is empty or starts above the region start
    logic prev;  // last entry whose start is not above the region start
    logic jn;    // this cell is the follower and the region ends at its start
    logic jp;    // this cell is the predecessor and ends at the region start
  } cell_flag_t;

endpackage

`default_nettype wire

[design/frtc_cell.sv]
// One table cell: holds one free region and moves data to or from its neighbors.
`default_nettype none

module frtc_cell #(
  parameter int ADDR_BITS = frtc_pkg::ADDR_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  frtc_pkg::cell_ctl_t       ctl,
  input  logic                      occ,
  input  logic [ADDR_BITS-1:0]      rs,
  input  logic [frtc_pkg::SIZE_W-1:0] rsize,
  input  logic [ADDR_BITS-1:0]      rend,
  input  logic                      left_after,
  input  logic [frtc_pkg::SIZE_W-1:0] left_size,
  input  logic [ADDR_BITS-1:0]      left_start,
  input  logic                      right_after,
  input  logic [frtc_pkg::SIZE_W-1:0] right_size,
  input  logic [ADDR_BITS-1:0]      right_start,
  output logic                      after,
  output logic [frtc_pkg::SIZE_W-1:0] size,
  output logic [ADDR_BITS-1:0]      start,
  output frtc_pkg::cell_flag_t      flag
);
  import frtc_pkg::*;

  logic                 f_after;
  logic [SIZE_W-1:0]    sum_r;
  logic [ADDR_BITS-1:0] my_end;
  cell_flag_t           flag_next;

  // Classify this cell against the region start and test for touching ends
  always_comb begin
    after          = !(occ && (start <= rs));
    my_end         = start + size[ADDR_BITS-1:0];
    flag_next.pos  = after && !left_after;
    flag_next.prev = !after && right_after;
    flag_next.jn   = flag_next.pos && occ && (start == rend);
    flag_next.jp   = flag_next.prev && (my_end == rs);
  end

  // Hold the compare result until the update cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      flag    <= '0;
      f_after <= 1'b0;
    end else if (ctl.eval) begin
      flag    <= flag_next;
      f_after <= after;
    end
  end

  // Precompute the merge sum, then shift or merge in the update cycle
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      sum_r <= size + rsize;
    end
    if (ctl.apply) begin
      case (ctl.op)
        OP_MERGE_BOTH: begin
          if (flag.prev) begin
            size <= sum_r + right_size;
          end else if (f_after) begin
            size  <= right_size;
            start <= right_start;
          end
        end
        OP_MERGE_NEXT: begin
          if (flag.pos) begin
            size  <= sum_r;
            start <= rs;
          end
        end
        OP_MERGE_PREV: begin
          if (flag.prev) begin
            size <= sum_r;
          end
        end
        OP_INSERT: begin
          if (flag.pos) begin
            size  <= rsize;
            start <= rs;
          end else if (f_after) begin
            size  <= left_size;
            start <= left_start;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/free_region_table_coalescing.sv]
// Top level of the address-ordered free region table with coalescing.
//
//   channel  valid      stall      payload   direction
//   request  req_valid  req_stall  req_item  in  (release or read)
//   result   rsp_valid  rsp_stall  rsp_item  out (one per request)
//
// Each item passes through a compare cycle, in which every cell compares its
// entry with the region, and then an update cycle, in which the row shifts or
// merges and the result is registered. The next item is taken in that update
// cycle. Reset clears the entry count and stalls requests; entry contents are
// left as they are. A stalled result holds the update cycle, and with it the
// request side.
`default_nettype none

module free_region_table_coalescing #(
  parameter int TABLE_ENTRIES = frtc_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS     = frtc_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  frtc_pkg::req_t req_item,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output frtc_pkg::rsp_t rsp_item
);
  import frtc_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  typedef enum logic [1:0] {PH_IDLE, PH_EVAL, PH_APPLY} phase_t;

  phase_t               phase;
  req_t                 req_r;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 out_free;
  logic                 fire;
  cell_ctl_t            ctl;
  rsp_t                 rsp_next;

  logic [ADDR_BITS-1:0] rs;
  logic [SIZE_W-1:0]    rsize;
  logic [ADDR_BITS-1:0] rend;

  logic [TABLE_ENTRIES-1:0] after_vec;
  logic [TABLE_ENTRIES-1:0] pos_vec;
  logic [TABLE_ENTRIES-1:0] jn_vec;
  logic [TABLE_ENTRIES-1:0] jp_vec;
  logic [SIZE_W-1:0]        size_arr  [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0]     start_arr [TABLE_ENTRIES];
  cell_flag_t               flag_arr  [TABLE_ENTRIES];

  logic                 jn;
  logic                 jp;
  logic                 full;
  logic [CMP_W-1:0]     idx_ext;
  logic                 read_hit;
  logic [IDX_W-1:0]     rd_sel;

  // Handshake: take a new item when idle or when the update cycle completes
  assign out_free  = !rsp_valid || !rsp_stall;
  assign fire      = (phase == PH_APPLY) && out_free;
  assign req_stall = rst || !((phase == PH_IDLE) || fire);
  assign accept    = req_valid && !req_stall;

  // Region operands taken from the held request
  assign rs    = req_r.region_start[ADDR_BITS-1:0];
  assign rsize = req_r.region_size;
  assign rend  = rs + rsize[ADDR_BITS-1:0];

  // Row of cells, each linked to both neighbors
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    logic                 occ;
    logic                 l_after;
    logic [SIZE_W-1:0]    l_size;
    logic [ADDR_BITS-1:0] l_start;
    logic                 r_after;
    logic [SIZE_W-1:0]    r_size;
    logic [ADDR_BITS-1:0] r_start;

    assign occ = (CNT_W'(k) < count);

    if (k == 0) begin : g_left_edge
      assign l_after = 1'b0;
      assign l_size  = '0;
      assign l_start = '0;
    end else begin : g_left_link
      assign l_after = after_vec[k-1];
      assign l_size  = size_arr[k-1];
      assign l_start = start_arr[k-1];
    end

    if (k == TABLE_ENTRIES - 1) begin : g_right_edge
      assign r_after = 1'b1;
      assign r_size  = '0;
      assign r_start = '0;
    end else begin : g_right_link
      assign r_after = after_vec[k+1];
      assign r_size  = size_arr[k+1];
      assign r_start = start_arr[k+1];
    end

    frtc_cell #(
      .ADDR_BITS (ADDR_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .occ         (occ),
      .rs          (rs),
      .rsize       (rsize),
      .rend        (rend),
      .left_after  (l_after),
      .left_size   (l_size),
      .left_start  (l_start),
      .right_after (r_after),
      .right_size  (r_size),
      .right_start (r_start),
      .after       (after_vec[k]),
      .size        (size_arr[k]),
      .start       (start_arr[k]),
      .flag        (flag_arr[k])
    );

    assign pos_vec[k] = flag_arr[k].pos;
    assign jn_vec[k]  = flag_arr[k].jn;
    assign jp_vec[k]  = flag_arr[k].jp;
  end

  // Decide the row update and the result
  always_comb begin
    jn       = |jn_vec;
    jp       = |jp_vec;
    full     = (count == CNT_W'(TABLE_ENTRIES));
    idx_ext  = CMP_W'(req_r.read_index);
    read_hit = (idx_ext < CMP_W'(count));
    rd_sel   = idx_ext[IDX_W-1:0];

    ctl.eval  = (phase == PH_EVAL);
    ctl.apply = fire;
    ctl.op    = OP_HOLD;
    count_next = count;

    rsp_next.entry_size  = '0;
    rsp_next.entry_start = '0;

    if (req_r.req_type == REQ_READ) begin
      if (read_hit) begin
        rsp_next.status      = ST_READ_OK;
        rsp_next.entry_size  = size_arr[rd_sel];
        rsp_next.entry_start = 32'(start_arr[rd_sel]);
      end else begin
        rsp_next.status = ST_BAD_INDEX;
      end
    end else if (jn && jp) begin
      rsp_next.status = ST_MERGE_BOTH;
      ctl.op          = OP_MERGE_BOTH;
      count_next      = count - CNT_W'(1);
    end else if (jn) begin
      rsp_next.status = ST_MERGE_NEXT;
      ctl.op          = OP_MERGE_NEXT;
    end else if (jp) begin
      rsp_next.status = ST_MERGE_PREV;
      ctl.op          = OP_MERGE_PREV;
    end else if (full) begin
      rsp_next.status = ST_FULL;
    end else begin
      rsp_next.status = ST_INSERT;
      ctl.op          = OP_INSERT;
      count_next      = count + CNT_W'(1);
    end

    rsp_next.entries_used = 7'(count_next);
  end

  // Sequence the phases, hold the request, count and result
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        req_r <= req_item;
      end
      case (phase)
        PH_IDLE: begin
          if (accept) begin
            phase <= PH_EVAL;
          end
        end
        PH_EVAL: begin
          phase <= PH_APPLY;
        end
        PH_APPLY: begin
          if (out_free) begin
            phase <= accept ? PH_EVAL : PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
      if (fire) begin
        rsp_valid <= 1'b1;
        rsp_item  <= rsp_next;
        count     <= count_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_pos_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pos_vec))
    else $error("more than one insert position");

  a_join_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0(jn_vec) && $onehot0(jp_vec))
    else $error("more than one merge candidate");

  a_eval_apply: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EVAL) |=> (phase == PH_APPLY))
    else $error("compare cycle not followed by update cycle");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (fire && (ctl.op == OP_INSERT)) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the table");
`endif

endmodule

`default_nettype wire
